[hw/rtl/edt_pkg.sv]
// Shared types and constants for the escape-decoding tokenizer.
// Holds the result-group type passed from front to back through the queue.
// No dependencies.
package edt_pkg;

    // Result slots one input beat can produce
    localparam int RES_MAX = 3;
    // Default depth of the front-to-back queue
    localparam int QDEPTH  = 4;

    // Characters that take part in escape decoding
    localparam logic [7:0] CH_BSL   = 8'h5C; // backslash
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_A     = 8'h61;

    // Control codes the escapes decode to
    localparam logic [7:0] CC_LF  = 8'd10;
    localparam logic [7:0] CC_TAB = 8'd9;
    localparam logic [7:0] CC_VT  = 8'd11;
    localparam logic [7:0] CC_BS  = 8'd8;
    localparam logic [7:0] CC_CR  = 8'd13;
    localparam logic [7:0] CC_FF  = 8'd12;
    localparam logic [7:0] CC_BEL = 8'd7;

    // Results caused by one input beat
    typedef struct packed {
        logic [1:0]               cnt;  // number of valid slots, 1 to 3
        logic [RES_MAX-1:0][7:0]  tok;  // token characters, slot 0 first
        logic [RES_MAX-1:0]       fin;  // end-of-token flags
    } t_grp;

endpackage

[hw/rtl/edt_front.sv]
// Front end: delimiter map registers, escape decoding and token hold-back.
// Turns each accepted input beat into a result group, pushed only if not empty.
// Depends on edt_pkg.
module edt_front
    import edt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_string,
    // configuration writes
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // queue push side
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_grp        o_q_grp
);

    logic [3:0][63:0] r_delim_map;
    logic             r_esc_open, n_esc_open;
    logic             r_held_valid, n_held_valid;
    logic [7:0]       r_held_byte, n_held_byte;

    logic             accept;
    logic [1:0]       dec_num;
    logic [1:0][7:0]  dec_chr;
    t_grp             grp;

    // Known escape lookup: bit 8 flags a known escape
    function automatic logic [8:0] esc_lookup(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            CH_N:     r = {1'b1, CC_LF};
            CH_T:     r = {1'b1, CC_TAB};
            CH_V:     r = {1'b1, CC_VT};
            CH_B:     r = {1'b1, CC_BS};
            CH_R:     r = {1'b1, CC_CR};
            CH_F:     r = {1'b1, CC_FF};
            CH_A:     r = {1'b1, CC_BEL};
            CH_BSL:   r = {1'b1, CH_BSL};
            CH_QMARK: r = {1'b1, CH_QMARK};
            CH_SQUOT: r = {1'b1, CH_SQUOT};
            CH_DQUOT: r = {1'b1, CH_DQUOT};
            default:  r = {1'b0, c};
        endcase
        return r;
    endfunction

    // Delimiter test; byte zero is never a delimiter
    function automatic logic is_delim(input logic [3:0][63:0] m, input logic [7:0] d);
        return (d != 8'd0) && m[d[7:6]][d[5:0]];
    endfunction

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    // Escape decoding: zero, one or two decoded characters per beat
    always_comb begin
        logic [8:0] lk;
        lk         = esc_lookup(i_in_byte);
        dec_num    = 2'd0;
        dec_chr    = '0;
        n_esc_open = r_esc_open;
        if (r_esc_open) begin
            n_esc_open = 1'b0;
            if (lk[8]) begin
                dec_num    = 2'd1;
                dec_chr[0] = lk[7:0];
            end else begin
                dec_num    = 2'd2;
                dec_chr[0] = CH_BSL;
                dec_chr[1] = i_in_byte;
            end
        end else if (i_in_byte == CH_BSL) begin
            // lone backslash at the end of the string goes out verbatim
            if (i_end_of_string) begin
                dec_num    = 2'd1;
                dec_chr[0] = CH_BSL;
            end else begin
                n_esc_open = 1'b1;
            end
        end else begin
            dec_num    = 2'd1;
            dec_chr[0] = i_in_byte;
        end
        if (i_end_of_string) begin
            n_esc_open = 1'b0;
        end
    end

    // Tokenising: feed decoded characters through the hold-back register
    always_comb begin
        logic       hv;
        logic [7:0] hb;
        logic [1:0] cnt;
        hv  = r_held_valid;
        hb  = r_held_byte;
        cnt = 2'd0;
        grp = '0;
        for (int k = 0; k < 2; k++) begin
            if (2'(k) < dec_num) begin
                if (is_delim(r_delim_map, dec_chr[k])) begin
                    if (hv) begin
                        grp.tok[cnt] = hb;
                        grp.fin[cnt] = 1'b1;
                        cnt          = cnt + 2'd1;
                        hv           = 1'b0;
                    end
                end else begin
                    if (hv) begin
                        grp.tok[cnt] = hb;
                        grp.fin[cnt] = 1'b0;
                        cnt          = cnt + 2'd1;
                    end
                    hb = dec_chr[k];
                    hv = 1'b1;
                end
            end
        end
        // flush at end of string
        if (i_end_of_string) begin
            if (hv) begin
                grp.tok[cnt] = hb;
                grp.fin[cnt] = 1'b1;
                cnt          = cnt + 2'd1;
            end
            hv = 1'b0;
        end
        grp.cnt      = cnt;
        n_held_valid = hv;
        n_held_byte  = hb;
    end

    assign o_q_push = accept && (grp.cnt != 2'd0);
    assign o_q_grp  = grp;

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_map  <= '0;
            r_esc_open   <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_byte  <= 8'd0;
        end else begin
            if (i_cfg_valid) begin
                r_delim_map[i_cfg_index] <= i_cfg_data;
            end
            if (accept) begin
                r_esc_open   <= n_esc_open;
                r_held_valid <= n_held_valid;
                r_held_byte  <= n_held_byte;
            end
        end
    end

endmodule

[hw/rtl/edt_queue.sv]
// Short queue of result groups between front and back ends.
// Register array with head and tail pointers and an occupancy count.
// Depends on edt_pkg.
module edt_queue
    import edt_pkg::*;
#(
    parameter int DEPTH = QDEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_grp i_grp,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_grp o_grp
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_grp            r_mem [DEPTH];
    logic [PW-1:0]   r_head, r_tail;
    logic [CW-1:0]   r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_grp   = r_mem[r_head];

    // Storage, written at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_grp;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= ptr_inc(r_tail);
            end
            if (i_pop) begin
                r_head <= ptr_inc(r_head);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[hw/rtl/edt_back.sv]
// Back end: walks the head result group's slots into a registered output
// stage, one beat per cycle while not stalled. Depends on edt_pkg.
module edt_back
    import edt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // queue pop side
    input  logic       i_q_valid,
    input  t_grp       i_q_grp,
    output logic       o_q_pop,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_token_byte,
    output logic       o_token_end,
    output logic       o_last_of_run
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_token_byte;
    logic       r_token_end;
    logic       r_last_of_run;
    logic       load;
    logic       last_slot;

    // Output register free or draining this cycle
    assign load      = i_q_valid && (!r_out_valid || !i_out_stall);
    assign last_slot = (r_idx == (i_q_grp.cnt - 2'd1));
    assign o_q_pop   = load && last_slot;

    // Slot counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= last_slot ? 2'd0 : r_idx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_token_byte  <= i_q_grp.tok[r_idx];
            r_token_end   <= i_q_grp.fin[r_idx];
            r_last_of_run <= last_slot;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_token_byte  = r_token_byte;
    assign o_token_end   = r_token_end;
    assign o_last_of_run = r_last_of_run;

endmodule

[hw/rtl/escape_decoding_tokenizer_top.sv]
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid/o_in_stall   i_in_byte, i_end_of_string
// out       output     o_out_valid/i_out_stall o_token_byte, o_token_end, o_last_of_run
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One input beat per cycle while the group queue has room; each beat yields
// zero to three output beats, which the back end sends one per cycle while
// the output is not stalled, so the output port sets the sustained rate.
// Synchronous active-low reset clears state, map and queue.
// Input stalls only when the queue is full; output stalls back up the queue.
// Depends on edt_pkg, edt_front, edt_queue, edt_back.
module escape_decoding_tokenizer_top
    import edt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_string,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_token_byte,
    output logic        o_token_end,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic q_push, q_full, q_pop, q_valid;
    t_grp push_grp, head_grp;

    assign o_cfg_ready = 1'b1;

    edt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_grp         (push_grp)
    );

    edt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_grp   (push_grp),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_grp   (head_grp)
    );

    edt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_grp       (head_grp),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_token_byte  (o_token_byte),
        .o_token_end   (o_token_end),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[sim/escape_decoding_tokenizer_top_tb.sv]
// Self-checking bench for the escape-decoding tokenizer top level.
// Runs a directed table, then random strings under several delimiter maps,
// with a behavioural predictor. Depends on edt_pkg and the tokenizer RTL.
module escape_decoding_tokenizer_top_tb
    import edt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 60;
    localparam int MAX_REPORTS    = 10;

    // Delimiter map register indexes
    localparam int REG_DELIM_MAP_0 = 0;
    localparam int REG_DELIM_MAP_3 = 3;

    // Escape partner with no defined meaning
    localparam logic [7:0] CH_UNKNOWN = 8'h71;

    localparam logic [7:0] ESC_CHARS [11] = '{
        CH_N, CH_T, CH_V, CH_B, CH_R, CH_F, CH_A,
        CH_BSL, CH_QMARK, CH_SQUOT, CH_DQUOT
    };

    // One output beat
    typedef struct packed {
        logic [7:0] chr;
        logic       fin;
        logic       run_end;
    } t_tok_beat;

    // Directed row; typed rows carry their expectation written out
    typedef struct packed {
        logic [7:0] chr;
        logic       eos;
        logic       typed;
        logic       has_res;
        t_tok_beat  res;
    } t_stim_row;

    localparam int NUM_ROWS      = 27;
    localparam int PHASE_B_FIRST = 2;

    localparam t_stim_row STIM_ROWS [NUM_ROWS] = '{
        // empty map: smallest byte alone, then trailing lone backslash
        '{8'h01,      1'b1, 1'b1, 1'b1, '{8'h01,  1'b1, 1'b1}},
        '{CH_BSL,     1'b1, 1'b1, 1'b1, '{CH_BSL, 1'b1, 1'b1}},
        // delimiter map loaded: every escape in turn, unknown one last
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_N,       1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_T,       1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_V,       1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_B,       1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_R,       1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_F,       1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_A,       1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_QMARK,   1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_SQUOT,   1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_DQUOT,   1'b0, 1'b0, 1'b0, '0},
        '{CH_BSL,     1'b0, 1'b0, 1'b0, '0},
        '{CH_UNKNOWN, 1'b1, 1'b0, 1'b0, '0},
        // top byte is a delimiter and nothing is held: no output
        '{8'hFF,      1'b1, 1'b1, 1'b0, '0}
    };

    // Map for the directed escapes: LF, '?', backslash, '@', 0x80, 0xFF and
    // the ignored bit for byte zero
    localparam logic [63:0] DIR_MAPS [4] = '{
        64'h8000_0000_0000_0401,
        64'h0000_0000_1000_0001,
        64'h0000_0000_0000_0001,
        64'h8000_0000_0000_0000
    };

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte       = 8'h00;
    logic        i_end_of_string = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [7:0]  o_token_byte;
    logic        o_token_end;
    logic        o_last_of_run;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index     = 2'd0;
    logic [63:0] i_cfg_data      = 64'd0;

    // Predictor state
    logic [63:0] delim_map [4] = '{default: 64'd0};
    logic        esc_open      = 1'b0;
    logic        held_vld      = 1'b0;
    logic [7:0]  held_chr      = 8'h00;

    t_tok_beat   step_beats [$];
    t_tok_beat   pending_tokens [$];

    int          items_sent  = 0;
    int          fail_count  = 0;
    int          quiet_cycles = 0;
    bit          no_idle     = 1'b0;
    bit          hold_req    = 1'b0;

    always #2 i_clk = ~i_clk;

    escape_decoding_tokenizer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_token_byte    (o_token_byte),
        .o_token_end     (o_token_end),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic bit is_delim(input logic [7:0] chr);
        return (chr != 8'h00) && delim_map[chr[7:6]][chr[5:0]];
    endfunction

    // bit 8 set: known escape, low byte is the decoded character
    function automatic logic [8:0] escape_code(input logic [7:0] chr);
        unique case (chr)
            CH_N:    return {1'b1, CC_LF};
            CH_T:    return {1'b1, CC_TAB};
            CH_V:    return {1'b1, CC_VT};
            CH_B:    return {1'b1, CC_BS};
            CH_R:    return {1'b1, CC_CR};
            CH_F:    return {1'b1, CC_FF};
            CH_A:    return {1'b1, CC_BEL};
            CH_BSL, CH_QMARK, CH_SQUOT, CH_DQUOT:
                     return {1'b1, chr};
            default: return 9'h000;
        endcase
    endfunction

    // One decoded character through the splitter; one byte is kept back
    function automatic void split_char(input logic [7:0] chr);
        if (is_delim(chr)) begin
            if (held_vld) begin
                step_beats.push_back('{held_chr, 1'b1, 1'b0});
                held_vld = 1'b0;
            end
        end else begin
            if (held_vld)
                step_beats.push_back('{held_chr, 1'b0, 1'b0});
            held_chr = chr;
            held_vld = 1'b1;
        end
    endfunction

    // Token beats caused by one raw input byte
    function automatic void decode_step(input logic [7:0] chr, input logic eos);
        logic [8:0] code;
        step_beats.delete();
        if (esc_open) begin
            code     = escape_code(chr);
            esc_open = 1'b0;
            if (code[8]) begin
                split_char(code[7:0]);
            end else begin
                split_char(CH_BSL);
                split_char(chr);
            end
        end else if (chr == CH_BSL) begin
            // trailing lone backslash goes through as it is
            if (eos)
                split_char(chr);
            else
                esc_open = 1'b1;
        end else begin
            split_char(chr);
        end
        if (eos) begin
            if (held_vld)
                step_beats.push_back('{held_chr, 1'b1, 1'b0});
            held_vld = 1'b0;
            esc_open = 1'b0;
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].run_end = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Offer one byte, wait for the beat, then book its expected tokens unless typed
    task automatic send_item(input logic [7:0] chr, input logic eos, input bit typed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_byte       <= chr;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_in_stall);
        decode_step(chr, eos);
        if (!typed) begin
            foreach (step_beats[k])
                pending_tokens.push_back(step_beats[k]);
        end
        items_sent++;
    endtask

    // Block must be idle: all four map registers in one go
    task automatic load_delim_maps(input logic [63:0] maps [4]);
        for (int r = REG_DELIM_MAP_0; r <= REG_DELIM_MAP_3; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= r[1:0];
            i_cfg_data  <= maps[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            delim_map[r] = maps[r];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Wait out all expected tokens plus the pipeline's own latency
    task automatic drain_tokens();
        i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_escape();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(1, 255));
        return ESC_CHARS[$urandom_range(0, 10)];
    endfunction

    function automatic logic [63:0] rand_map(input int ands);
        logic [63:0] w;
        w = {$urandom, $urandom};
        repeat (ands) w &= {$urandom, $urandom};
        return w;
    endfunction

    // Random string: escape pairs, printable text, raw bytes, and now and
    // then a backslash left open at the end
    task automatic send_string();
        int   len;
        int   pick;
        logic eos;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            eos  = (k == len - 1);
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                send_item(CH_BSL, 1'b0, 1'b0);
                send_item(pick_escape(), eos, 1'b0);
            end else if (pick == 3 && eos) begin
                send_item(CH_BSL, 1'b1, 1'b0);
            end else if (pick <= 4) begin
                send_item(8'($urandom_range(1, 255)), eos, 1'b0);
            end else begin
                send_item(8'($urandom_range(8'h20, 8'h7E)), eos, 1'b0);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Token sink: random stall per beat, one long hold on request
    // ---------------------------------------------------------------
    initial begin : token_sink
        int gap;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // ---------------------------------------------------------------
    // Checker: each output beat against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : token_check
        t_tok_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_tokens.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected token beat: %02h end %0b last %0b",
                             o_token_byte, o_token_end, o_last_of_run);
            end else begin
                want = pending_tokens.pop_front();
                if (o_token_byte !== want.chr || o_token_end !== want.fin ||
                    o_last_of_run !== want.run_end) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"token mismatch: expected %02h end %0b last %0b,",
                                  " got %02h end %0b last %0b"},
                                 want.chr, want.fin, want.run_end,
                                 o_token_byte, o_token_end, o_last_of_run);
                end
            end
        end
    end

    // Watchdog: too long without any beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        logic [63:0] maps [4];
        int          target;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (r == PHASE_B_FIRST) begin
                drain_tokens();
                load_delim_maps(DIR_MAPS);
            end
            send_item(STIM_ROWS[r].chr, STIM_ROWS[r].eos, STIM_ROWS[r].typed);
            if (STIM_ROWS[r].typed && STIM_ROWS[r].has_res)
                pending_tokens.push_back(STIM_ROWS[r].res);
        end

        // random phases: all delimiters, sparse, medium with a long output
        // hold, dense, none
        for (int ph = 0; ph < 5; ph++) begin
            drain_tokens();
            unique case (ph)
                0:       maps = '{default: '1};
                1:       foreach (maps[i]) maps[i] = rand_map(2);
                2:       foreach (maps[i]) maps[i] = rand_map(1);
                3:       foreach (maps[i]) maps[i] = rand_map(0);
                default: maps = '{default: '0};
            endcase
            load_delim_maps(maps);
            no_idle = (ph == 1);
            if (ph == 2)
                hold_req = 1'b1;
            target = items_sent + ((ph == 0) ? 10 : 15);
            while (items_sent < target) send_string();
        end
        drain_tokens();

        fail_count += pending_tokens.size();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/edt_pkg.sv
hw/rtl/edt_front.sv
hw/rtl/edt_queue.sv
hw/rtl/edt_back.sv
hw/rtl/escape_decoding_tokenizer_top.sv
sim/escape_decoding_tokenizer_top_tb.sv
